// ----- hdl/rwpg_pkg.sv -----
// Shared types and constants for the rainbow wheel pixel generator.
`timescale 1ns / 1ps
`default_nettype none

package rwpg_pkg;

    // Register map: index taken from paddr[4:2]
    localparam int unsigned REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_REVERSE_DIRECTION = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GLOBAL_LEVEL      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_NIGHT_LEVEL       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_NIGHT_ENABLED     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STRIP_LENGTH      = 3'd4;

    localparam int unsigned PADDR_W  = 5;
    localparam int unsigned PDATA_W  = 32;
    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned LENGTH_W = 11;
    localparam int unsigned INDEX_W  = 10;
    localparam int unsigned CHAN_W   = 8;

    // Register reset values
    localparam logic                RST_REVERSE_DIRECTION = 1'b0;
    localparam logic [LEVEL_W-1:0]  RST_GLOBAL_LEVEL      = 8'd255;
    localparam logic [LEVEL_W-1:0]  RST_NIGHT_LEVEL       = 8'd64;
    localparam logic                RST_NIGHT_ENABLED     = 1'b0;
    localparam logic [LENGTH_W-1:0] RST_STRIP_LENGTH      = 11'd60;

    // Colour wheel segment bounds and full scale
    localparam logic [CHAN_W-1:0] WHEEL_SEG1 = 8'd85;
    localparam logic [CHAN_W-1:0] WHEEL_SEG2 = 8'd170;
    localparam logic [CHAN_W-1:0] CHAN_FULL  = 8'd255;

    // Input mode codes
    localparam logic MODE_RENDER  = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    // Configuration held by the register block
    typedef struct packed {
        logic                reverse_direction;
        logic [LEVEL_W-1:0]  global_level;
        logic [LEVEL_W-1:0]  night_level;
        logic                night_enabled;
        logic [LENGTH_W-1:0] strip_length;
    } t_cfg;

endpackage

`default_nettype wire

// ----- hdl/rainbow_wheel_pixel_generator_top.sv -----
// Top level of the rainbow wheel pixel generator: input register, colour stage, result register.
`timescale 1ns / 1ps
`default_nettype none

// Rainbow wheel pixel generator. Takes one transaction per clock unless stalled: a render
// transaction (i_mode 0) yields one pixel colour and a last-pixel flag via the input and result
// registers; an advance transaction (i_mode 1) yields no result and steps the hue offset by one,
// forward or backward, as it passes the colour stage. The block sustains that rate; it is set by
// the single colour stage between the input register and the result register, which holds the
// wheel lookup and one 8x8 brightness multiply per channel. Back-pressure on the result side
// stalls the input only when both registers are full. No clearing pass follows reset. The user
// must write registers over the APB-style port only while the block is idle; the block does not
// enforce this. MAX_LEDS caps the strip length used for the last-pixel test.
module rainbow_wheel_pixel_generator_top #(
    parameter int unsigned MAX_LEDS = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [rwpg_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [rwpg_pkg::PDATA_W-1:0]   pwdata,
    output logic      [rwpg_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    // input channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_mode,
    input  wire logic [rwpg_pkg::INDEX_W-1:0]   i_pixel_index,
    // output channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic      [rwpg_pkg::CHAN_W-1:0]    o_red,
    output logic      [rwpg_pkg::CHAN_W-1:0]    o_green,
    output logic      [rwpg_pkg::CHAN_W-1:0]    o_blue,
    output logic                                o_last_pixel
);

    localparam int unsigned CMP_W = 17;
    localparam logic [CMP_W-1:0] MaxLen = CMP_W'(MAX_LEDS);

    rwpg_pkg::t_cfg cfg;

    logic                          r_in_valid;
    logic                          r_mode;
    logic [rwpg_pkg::INDEX_W-1:0]  r_idx;
    logic [rwpg_pkg::CHAN_W-1:0]   r_hue_offset;
    logic [rwpg_pkg::CHAN_W-1:0]   n_hue_offset;
    logic                          r_out_valid;
    logic [rwpg_pkg::CHAN_W-1:0]   r_red;
    logic [rwpg_pkg::CHAN_W-1:0]   r_green;
    logic [rwpg_pkg::CHAN_W-1:0]   r_blue;
    logic                          r_last;

    logic                          in_fire;
    logic                          out_free;
    logic                          s1_fire;
    logic                          s1_render;
    logic [rwpg_pkg::CHAN_W-1:0]   sum_pos;
    logic [rwpg_pkg::CHAN_W-1:0]   pos;
    logic [rwpg_pkg::LEVEL_W-1:0]  level;
    logic [CMP_W-1:0]              eff_len;
    logic                          last;
    logic [rwpg_pkg::CHAN_W-1:0]   c_red;
    logic [rwpg_pkg::CHAN_W-1:0]   c_green;
    logic [rwpg_pkg::CHAN_W-1:0]   c_blue;

    rwpg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Handshake: an advance needs no result slot, a render needs a free result register
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_in_valid && ((r_mode == rwpg_pkg::MODE_ADVANCE) || out_free);
    assign s1_render  = s1_fire && (r_mode == rwpg_pkg::MODE_RENDER);
    assign o_in_stall = r_in_valid && !s1_fire;
    assign in_fire    = i_in_valid && !o_in_stall;

    // Capture the input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (s1_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mode <= i_mode;
            r_idx  <= i_pixel_index;
        end
    end

    // Step the hue offset on an advance
    always_comb begin
        n_hue_offset = r_hue_offset;
        if (s1_fire && (r_mode == rwpg_pkg::MODE_ADVANCE)) begin
            if (cfg.reverse_direction) begin
                n_hue_offset = r_hue_offset - 8'd1;
            end else begin
                n_hue_offset = r_hue_offset + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_offset <= '0;
        end else begin
            r_hue_offset <= n_hue_offset;
        end
    end

    // Form the wheel position, negated when running backward
    assign sum_pos = r_idx[rwpg_pkg::CHAN_W-1:0] + r_hue_offset;
    assign pos     = cfg.reverse_direction ? (8'd0 - sum_pos) : sum_pos;
    assign level   = cfg.night_enabled ? cfg.night_level : cfg.global_level;

    rwpg_color u_color (
        .i_pos   (pos),
        .i_level (level),
        .o_red   (c_red),
        .o_green (c_green),
        .o_blue  (c_blue)
    );

    // Flag the last pixel against the capped strip length
    assign eff_len = (CMP_W'(cfg.strip_length) > MaxLen) ? MaxLen : CMP_W'(cfg.strip_length);
    assign last    = (eff_len != '0) && (CMP_W'(r_idx) == (eff_len - CMP_W'(1)));

    // Load the result register, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_render) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_render) begin
            r_red   <= c_red;
            r_green <= c_green;
            r_blue  <= c_blue;
            r_last  <= last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_red        = r_red;
    assign o_green      = r_green;
    assign o_blue       = r_blue;
    assign o_last_pixel = r_last;

    // A stall on the input only ever comes from a blocked render
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall
                        && (r_mode == rwpg_pkg::MODE_RENDER)))
        else $error("input stalled without a blocked render");

    // A render leaving the colour stage is always presented next cycle
    a_render_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_render |=> o_out_valid)
        else $error("render transaction lost");

    // An advance moves the offset by exactly one step
    a_advance_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && (r_mode == rwpg_pkg::MODE_ADVANCE)) |=>
        ((r_hue_offset == $past(r_hue_offset) + 8'd1)
         || (r_hue_offset == $past(r_hue_offset) - 8'd1)))
        else $error("hue offset step wrong");

    // The offset holds when no advance passes
    a_offset_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s1_fire && (r_mode == rwpg_pkg::MODE_ADVANCE)) |=> $stable(r_hue_offset))
        else $error("hue offset changed without an advance");

endmodule

`default_nettype wire

// ----- hdl/rwpg_cfg.sv -----
// APB-style configuration registers of the rainbow wheel pixel generator.
`timescale 1ns / 1ps
`default_nettype none

module rwpg_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rwpg_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [rwpg_pkg::PDATA_W-1:0]  pwdata,
    output logic      [rwpg_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    output rwpg_pkg::t_cfg                     o_cfg
);

    rwpg_pkg::t_cfg                     r_cfg;
    rwpg_pkg::t_cfg                     n_cfg;
    logic [rwpg_pkg::REG_IDX_W-1:0]     reg_idx;
    logic                               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[rwpg_pkg::PADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;

    // Decode the write and mask data to register width
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                rwpg_pkg::REG_REVERSE_DIRECTION: n_cfg.reverse_direction = pwdata[0];
                rwpg_pkg::REG_GLOBAL_LEVEL:
                    n_cfg.global_level = pwdata[rwpg_pkg::LEVEL_W-1:0];
                rwpg_pkg::REG_NIGHT_LEVEL:
                    n_cfg.night_level = pwdata[rwpg_pkg::LEVEL_W-1:0];
                rwpg_pkg::REG_NIGHT_ENABLED:     n_cfg.night_enabled = pwdata[0];
                rwpg_pkg::REG_STRIP_LENGTH:
                    n_cfg.strip_length = pwdata[rwpg_pkg::LENGTH_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    // Hold the registers, load reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reverse_direction <= rwpg_pkg::RST_REVERSE_DIRECTION;
            r_cfg.global_level      <= rwpg_pkg::RST_GLOBAL_LEVEL;
            r_cfg.night_level       <= rwpg_pkg::RST_NIGHT_LEVEL;
            r_cfg.night_enabled     <= rwpg_pkg::RST_NIGHT_ENABLED;
            r_cfg.strip_length      <= rwpg_pkg::RST_STRIP_LENGTH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Return the addressed register, zero extended
    always_comb begin
        case (reg_idx)
            rwpg_pkg::REG_REVERSE_DIRECTION:
                prdata = rwpg_pkg::PDATA_W'(r_cfg.reverse_direction);
            rwpg_pkg::REG_GLOBAL_LEVEL: prdata = rwpg_pkg::PDATA_W'(r_cfg.global_level);
            rwpg_pkg::REG_NIGHT_LEVEL:  prdata = rwpg_pkg::PDATA_W'(r_cfg.night_level);
            rwpg_pkg::REG_NIGHT_ENABLED:
                prdata = rwpg_pkg::PDATA_W'(r_cfg.night_enabled);
            rwpg_pkg::REG_STRIP_LENGTH: prdata = rwpg_pkg::PDATA_W'(r_cfg.strip_length);
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- hdl/rwpg_color.sv -----
// Colour wheel lookup and brightness scaling for one wheel position.
`timescale 1ns / 1ps
`default_nettype none

module rwpg_color (
    input  wire logic [rwpg_pkg::CHAN_W-1:0]  i_pos,
    input  wire logic [rwpg_pkg::LEVEL_W-1:0] i_level,
    output logic      [rwpg_pkg::CHAN_W-1:0]  o_red,
    output logic      [rwpg_pkg::CHAN_W-1:0]  o_green,
    output logic      [rwpg_pkg::CHAN_W-1:0]  o_blue
);

    // Scale c by level/255, floored; x/255 == (x + (x >> 8) + 1) >> 8 for x up to 255*255
    function automatic logic [rwpg_pkg::CHAN_W-1:0] scale_chan(
        input logic [rwpg_pkg::CHAN_W-1:0]  c,
        input logic [rwpg_pkg::LEVEL_W-1:0] level
    );
        logic [15:0] prod;
        logic [16:0] sum;
        prod = 16'(c) * 16'(level);
        sum  = 17'(prod) + 17'(prod[15:8]) + 17'd1;
        return sum[15:8];
    endfunction

    logic [rwpg_pkg::CHAN_W-1:0] w;
    logic [rwpg_pkg::CHAN_W-1:0] v;
    logic [9:0]                  v3;
    logic [rwpg_pkg::CHAN_W-1:0] ramp;
    logic [rwpg_pkg::CHAN_W-1:0] wr;
    logic [rwpg_pkg::CHAN_W-1:0] wg;
    logic [rwpg_pkg::CHAN_W-1:0] wb;

    // Pick the wheel segment and its local ramp value
    always_comb begin
        w = rwpg_pkg::CHAN_FULL - i_pos;
        if (w < rwpg_pkg::WHEEL_SEG1) begin
            v = w;
        end else if (w < rwpg_pkg::WHEEL_SEG2) begin
            v = w - rwpg_pkg::WHEEL_SEG1;
        end else begin
            v = w - rwpg_pkg::WHEEL_SEG2;
        end
        v3   = {1'b0, v, 1'b0} + {2'b00, v};
        ramp = v3[rwpg_pkg::CHAN_W-1:0];

        if (w < rwpg_pkg::WHEEL_SEG1) begin
            wr = rwpg_pkg::CHAN_FULL - ramp;
            wg = '0;
            wb = ramp;
        end else if (w < rwpg_pkg::WHEEL_SEG2) begin
            wr = '0;
            wg = ramp;
            wb = rwpg_pkg::CHAN_FULL - ramp;
        end else begin
            wr = ramp;
            wg = rwpg_pkg::CHAN_FULL - ramp;
            wb = '0;
        end
    end

    // Apply brightness per channel
    assign o_red   = scale_chan(wr, i_level);
    assign o_green = scale_chan(wg, i_level);
    assign o_blue  = scale_chan(wb, i_level);

endmodule

`default_nettype wire
